FILE: sv/glb_pkg.sv
// Shared types and constants for the Gaussian line blur core.
// No dependencies; used by every module of the block.
package glb_pkg;

    localparam int NUM_TAPS = 8;   // weight registers, distance 0..7
    localparam int AGE_W    = 3;   // pixel age within the window, up to 7
    localparam int FILL_W   = 4;   // line fill count, up to 15
    localparam int WGT_W    = 16;  // Q1.15 weight
    localparam int PIX_W    = 32;
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int ACC_W    = 28;  // 15 taps of 8 x 16 bits
    localparam int WSUM_W   = 20;  // 15 taps of 16 bits
    localparam int CFG_IDX_W = 8;

    localparam logic [CH_W-1:0]  CH_MAX  = 8'hFF;
    localparam logic [WGT_W-1:0] W_UNITY = 16'h8000;  // 1.0 in Q1.15

    // one job per accepted pixel that causes results
    typedef struct packed {
        logic [AGE_W-1:0]  first_age;
        logic [FILL_W-1:0] fill;
        logic              last;
    } job_t;

    // back end status seen by the front end
    typedef struct packed {
        logic busy;
        logic job_pop;
    } back_stat_t;

endpackage

FILE: sv/gaussian_line_blur_core.sv
// Gaussian line blur core: top level with weight registers.
// Depends on glb_pkg, glb_front, glb_job_fifo, glb_back.
//
// Usage:
//   s_ channel: one packed ARGB pixel per beat, s_line_end_in on the last
//   pixel of a line. m_ channel: blurred pixels, m_line_end_out on the last
//   output of a line, m_run_last on the final result caused by a beat.
//   cfg_ channel: writes tap weight cfg_index (0..7, Q1.15); other indexes
//   are dropped. Write only while the block is idle.
// Results and flow:
//   A pixel beat causes zero, one or (on a line end) up to MAX_RADIUS+1
//   results. Each result is accumulated one tap per cycle through four
//   8x16 multipliers, divided one quotient bit per cycle per channel, then
//   presented in the output state. The first result follows its beat through
//   the job queue, the idle state that lifts the job off it, then accumulate
//   and divide. Beats that cause no result are taken every cycle while no
//   job is queued or in progress; after a beat that causes results, the
//   next beat waits until the last of them is taken.
// Reset:
//   aresetn clears line fill, the job queue and the output valid; weight 0
//   returns to 1.0 and the others to zero.
// Stall:
//   With m_ready low the result holds in the quotient registers and the back
//   end waits; s_ready stays low until the last result drains.
module gaussian_line_blur_core #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [glb_pkg::PIX_W-1:0]       s_pixel_in,
    input  logic                            s_line_end_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [glb_pkg::PIX_W-1:0]       m_pixel_out,
    output logic                            m_line_end_out,
    output logic                            m_run_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [glb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [glb_pkg::WGT_W-1:0]       cfg_data
);
    localparam int WIN = 2 * MAX_RADIUS + 1;

    logic [glb_pkg::NUM_TAPS-1:0][glb_pkg::WGT_W-1:0] weights_reg;
    logic [WIN-1:0][glb_pkg::PIX_W-1:0] window;
    logic job_push, fifo_not_empty;
    glb_pkg::job_t push_job, head_job;
    glb_pkg::back_stat_t stat;

    // weight registers always take a write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weights_reg <= {{(glb_pkg::NUM_TAPS-1){glb_pkg::WGT_W'(0)}},
                            glb_pkg::W_UNITY};
        end else if (cfg_valid && cfg_index < glb_pkg::CFG_IDX_W'(glb_pkg::NUM_TAPS)) begin
            weights_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // front holds off while any job is queued or in progress
    glb_front #(.MAX_RADIUS(MAX_RADIUS)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_in   (s_pixel_in),
        .s_line_end_in(s_line_end_in),
        .hold         (fifo_not_empty || stat.busy),
        .window       (window),
        .job_push     (job_push),
        .job          (push_job)
    );

    glb_job_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (stat.job_pop),
        .not_empty(fifo_not_empty),
        .head     (head_job)
    );

    glb_back #(.MAX_RADIUS(MAX_RADIUS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .job_valid     (fifo_not_empty),
        .job           (head_job),
        .window        (window),
        .weights       (weights_reg),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_out   (m_pixel_out),
        .m_line_end_out(m_line_end_out),
        .m_run_last    (m_run_last)
    );
endmodule

FILE: sv/glb_front.sv
// Front end: accepts pixels, shifts the pixel window, tracks line fill
// and turns each pixel that causes results into a job. Depends on glb_pkg.
module glb_front #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [glb_pkg::PIX_W-1:0]             s_pixel_in,
    input  logic                                  s_line_end_in,
    input  logic                                  hold,
    output logic [2*MAX_RADIUS:0][glb_pkg::PIX_W-1:0] window,
    output logic                                  job_push,
    output glb_pkg::job_t                         job
);
    localparam int WIN = 2 * MAX_RADIUS + 1;
    localparam logic [glb_pkg::FILL_W-1:0] WIN_F = glb_pkg::FILL_W'(WIN);
    localparam logic [glb_pkg::FILL_W-1:0] RAD_F = glb_pkg::FILL_W'(MAX_RADIUS);

    logic [WIN-1:0][glb_pkg::PIX_W-1:0] win_reg;
    logic [glb_pkg::FILL_W-1:0] fill_reg, fill_next, fill_inc, oldest;
    logic accept;

    assign s_ready = !hold;
    assign accept  = s_valid && s_ready;
    assign window  = win_reg;

    always_comb begin
        fill_inc  = (fill_reg < WIN_F) ? fill_reg + 1'b1 : fill_reg;
        fill_next = s_line_end_in ? '0 : fill_inc;
        oldest    = fill_inc - 1'b1;
        if (oldest > RAD_F) begin
            oldest = RAD_F;
        end
        job.fill      = fill_inc;
        job.last      = s_line_end_in;
        job.first_age = s_line_end_in ? oldest[glb_pkg::AGE_W-1:0]
                                      : RAD_F[glb_pkg::AGE_W-1:0];
        job_push = accept && (s_line_end_in || fill_inc > RAD_F);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (accept) begin
            fill_reg <= fill_next;
        end
    end

    // shift the window, newest at index 0
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= {win_reg[WIN-2:0], s_pixel_in};
        end
    end
endmodule

FILE: sv/glb_job_fifo.sv
// Two-entry job queue between front and back end.
// Depends on glb_pkg.
module glb_job_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  glb_pkg::job_t push_job,
    input  logic          pop,
    output logic          not_empty,
    output glb_pkg::job_t head
);
    glb_pkg::job_t mem_reg [2];
    logic wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

FILE: sv/glb_back.sv
// Back end: per result of a job, accumulate taps one per cycle, divide each
// channel by the weight sum bit by bit, then present it. Depends on glb_pkg.
module glb_back #(
    parameter int MAX_RADIUS = 7
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      job_valid,
    input  glb_pkg::job_t                             job,
    input  logic [2*MAX_RADIUS:0][glb_pkg::PIX_W-1:0] window,
    input  logic [glb_pkg::NUM_TAPS-1:0][glb_pkg::WGT_W-1:0] weights,
    output glb_pkg::back_stat_t                       stat,
    output logic                                      m_valid,
    input  logic                                      m_ready,
    output logic [glb_pkg::PIX_W-1:0]                 m_pixel_out,
    output logic                                      m_line_end_out,
    output logic                                      m_run_last
);
    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int IDX_W = $clog2(WIN);
    localparam logic [4:0] RAD5 = 5'(MAX_RADIUS);
    localparam logic [4:0] WIN5 = 5'(WIN);
    localparam logic [3:0] TAP_LAST = 4'(2 * MAX_RADIUS);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ACC  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    glb_pkg::job_t job_reg;
    logic [glb_pkg::AGE_W-1:0] age_reg;
    logic [3:0] tap_reg;
    logic [3:0] bit_reg;
    logic [glb_pkg::NUM_CH-1:0][glb_pkg::ACC_W-1:0] acc_reg;
    logic [glb_pkg::NUM_CH-1:0][glb_pkg::CH_W-1:0] q_reg;
    logic [glb_pkg::NUM_CH-1:0] sat_reg;
    logic [glb_pkg::WSUM_W-1:0] wsum_reg;
    logic [glb_pkg::PIX_W-1:0] pix_val;
    logic done;

    logic [4:0] a_sum, a_pos, fill5;
    logic tap_ok;
    logic [2:0] tap_dist;
    logic [glb_pkg::WGT_W-1:0] w;
    logic [glb_pkg::PIX_W-1:0] p;
    logic [glb_pkg::ACC_W-1:0] div_cmp;

    always_comb begin
        a_sum  = 5'(age_reg) + 5'(tap_reg);
        a_pos  = a_sum - RAD5;
        fill5  = 5'(job_reg.fill);
        tap_ok = (a_sum >= RAD5) && (a_pos < fill5) && (a_pos < WIN5);
        tap_dist = (5'(tap_reg) >= RAD5) ? 3'(5'(tap_reg) - RAD5)
                                         : 3'(RAD5 - 5'(tap_reg));
        w      = tap_ok ? weights[tap_dist] : '0;
        p      = tap_ok ? window[a_pos[IDX_W-1:0]] : '0;
        div_cmp = glb_pkg::ACC_W'(wsum_reg) << bit_reg;
        done   = !job_reg.last || age_reg == '0;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_ACC;
            ST_ACC:  if (tap_reg == TAP_LAST) state_next = ST_DIV;
            ST_DIV:  if (bit_reg == 4'd0) state_next = ST_OUT;
            ST_OUT:  if (m_ready) state_next = done ? ST_IDLE : ST_ACC;
            default: state_next = ST_IDLE;
        endcase
    end

    assign stat.busy    = state_reg != ST_IDLE;
    assign stat.job_pop = state_reg == ST_IDLE && job_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                job_reg  <= job;
                age_reg  <= job.first_age;
                tap_reg  <= '0;
                acc_reg  <= '0;
                wsum_reg <= '0;
            end
            ST_ACC: begin
                for (int c = 0; c < glb_pkg::NUM_CH; c++) begin
                    acc_reg[c] <= acc_reg[c] + glb_pkg::ACC_W'(
                        p[8*c +: glb_pkg::CH_W] * w);
                end
                wsum_reg <= wsum_reg + glb_pkg::WSUM_W'(w);
                tap_reg  <= tap_reg + 1'b1;
                bit_reg  <= 4'd8;
                sat_reg  <= '0;
            end
            ST_DIV: begin
                // step eight only detects saturation, then restoring division
                for (int c = 0; c < glb_pkg::NUM_CH; c++) begin
                    if (bit_reg == 4'd8) begin
                        sat_reg[c] <= acc_reg[c] >= div_cmp;
                    end else if (acc_reg[c] >= div_cmp) begin
                        acc_reg[c] <= acc_reg[c] - div_cmp;
                        q_reg[c][bit_reg[2:0]] <= 1'b1;
                    end else begin
                        q_reg[c][bit_reg[2:0]] <= 1'b0;
                    end
                end
                bit_reg <= bit_reg - 1'b1;
            end
            ST_OUT: begin
                if (m_ready) begin
                    age_reg  <= age_reg - 1'b1;
                    tap_reg  <= '0;
                    acc_reg  <= '0;
                    wsum_reg <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int c = 0; c < glb_pkg::NUM_CH; c++) begin
            pix_val[8*c +: glb_pkg::CH_W] = (wsum_reg == '0) ? '0 :
                (sat_reg[c] ? glb_pkg::CH_MAX : q_reg[c]);
        end
    end

    assign m_valid        = state_reg == ST_OUT;
    assign m_pixel_out    = pix_val;
    assign m_line_end_out = job_reg.last && age_reg == '0;
    assign m_run_last     = done;
endmodule

FILE: sv/glb_checker.sv
// Port-level checks for the Gaussian line blur core, bound to the top.
// Depends on glb_pkg and gaussian_line_blur_core.
module glb_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [glb_pkg::PIX_W-1:0]     m_pixel_out,
    input logic                          m_line_end_out,
    input logic                          m_run_last
);
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result valid after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_out))
        else $error("stalled result changed");

    a_line_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_line_end_out |-> m_run_last)
        else $error("line end without run last");

    a_hold_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("pixel taken while a result waits");

    a_run_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_run_last |=> !s_ready)
        else $error("pixel taken before run finished");
endmodule

bind gaussian_line_blur_core glb_checker u_glb_checker (.*);

FILE: bench/gaussian_line_blur_core_tb.sv
// Self-checking bench for gaussian_line_blur_core: a line blur predictor in
// the bench, directed pixel table, fixed kernels, then random lines. Depends on glb_pkg.
`timescale 1ns / 100ps

module gaussian_line_blur_core_tb;

    localparam int RADIUS    = 7;
    localparam int WIN_DEPTH = 2 * RADIUS + 1;
    localparam int FILL_SAT  = 15;
    localparam int DRAIN_CYC = 60;

    // weight register indexes
    localparam logic [glb_pkg::CFG_IDX_W-1:0] IDX_BEYOND = 8'd8;  // dropped by the block
    localparam logic [glb_pkg::CFG_IDX_W-1:0] IDX_TOP    = 8'd255;

    localparam logic [glb_pkg::WGT_W-1:0] W_ONE = 16'h8000;
    localparam logic [glb_pkg::WGT_W-1:0] W_MAX = 16'hFFFF;

    typedef struct {
        logic [glb_pkg::PIX_W-1:0] pixel;
        logic                      line_end;
        logic                      run_last;
    } blur_res_t;

    typedef struct {
        logic [glb_pkg::PIX_W-1:0] pixel;
        logic                      line_end;
        logic                      has_check;   // 1: first result is typed below
        logic [glb_pkg::PIX_W-1:0] check_pixel;
    } pix_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [glb_pkg::PIX_W-1:0]     s_pixel_in = '0;
    logic                          s_line_end_in = 1'b0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [glb_pkg::PIX_W-1:0]     m_pixel_out;
    logic                          m_line_end_out;
    logic                          m_run_last;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [glb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [glb_pkg::WGT_W-1:0]     cfg_data = '0;

    // predictor state: its own copy of weights, window and line fill
    logic [glb_pkg::WGT_W-1:0] tap_w [glb_pkg::NUM_TAPS];
    logic [glb_pkg::PIX_W-1:0] window [WIN_DEPTH];
    int                        fill_cnt;

    blur_res_t blurred_q [$];
    int        mismatches = 0;
    int        src_idle_pct = 6;
    int        dst_idle_pct = 57;
    bit        dst_hold = 1'b0;     // long receiver hold-off

    gaussian_line_blur_core #(.MAX_RADIUS(RADIUS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_in(s_pixel_in), .s_line_end_in(s_line_end_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pixel_out(m_pixel_out), .m_line_end_out(m_line_end_out),
        .m_run_last(m_run_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("gaussian_line_blur_core_tb: FAIL");
        $finish;
    end

    // Weighted per-channel average of the pixel at the given age.
    function automatic logic [glb_pkg::PIX_W-1:0] blur_pixel(int age, int fill);
        logic [63:0]               acc [glb_pkg::NUM_CH];
        logic [63:0]               wsum;
        logic [63:0]               q;
        logic [glb_pkg::PIX_W-1:0] res;
        int                        a;
        int                        tap_dist;
        wsum = 0;
        res = '0;
        for (int c = 0; c < glb_pkg::NUM_CH; c++) acc[c] = 0;
        for (int d = -RADIUS; d <= RADIUS; d++) begin
            a = age + d;
            tap_dist = (d < 0) ? -d : d;
            if (a < 0 || a >= fill || a >= WIN_DEPTH) continue;
            for (int c = 0; c < glb_pkg::NUM_CH; c++)
                acc[c] += 64'(window[a][8*c +: 8]) * 64'(tap_w[tap_dist]);
            wsum += 64'(tap_w[tap_dist]);
        end
        for (int c = 0; c < glb_pkg::NUM_CH; c++) begin
            q = 0;
            if (wsum != 0) begin
                q = acc[c] / wsum;
                if (q > 64'(glb_pkg::CH_MAX)) q = 64'(glb_pkg::CH_MAX);
            end
            res[8*c +: 8] = q[7:0];
        end
        return res;
    endfunction

    // Shift the pixel in and queue every blurred pixel it releases.
    function automatic int push_pixel(logic [glb_pkg::PIX_W-1:0] pix, logic last);
        blur_res_t r;
        int        oldest;
        int        n;
        n = 0;
        for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = pix;
        if (fill_cnt < FILL_SAT) fill_cnt++;
        if (!last) begin
            if (fill_cnt > RADIUS) begin
                r.pixel = blur_pixel(RADIUS, fill_cnt);
                r.line_end = 1'b0;
                r.run_last = 1'b1;
                blurred_q.push_back(r);
                n = 1;
            end
            return n;
        end
        oldest = (fill_cnt - 1 > RADIUS) ? RADIUS : fill_cnt - 1;
        for (int age = oldest; age >= 0; age--) begin
            r.pixel = blur_pixel(age, fill_cnt);
            r.line_end = (age == 0);
            r.run_last = (age == 0);
            blurred_q.push_back(r);
            n++;
        end
        fill_cnt = 0;
        return n;
    endfunction

    task automatic note_mismatch(string what, logic [glb_pkg::PIX_W-1:0] exp_v,
                                 logic [glb_pkg::PIX_W-1:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h got %h", what, exp_v, act_v);
    endtask

    // Receiver: random stalls, plus the long hold-off flag.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= !dst_hold && ($urandom_range(99) >= dst_idle_pct);
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge aclk) begin
        blur_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (blurred_q.size() == 0) begin
                note_mismatch("unexpected beat", '0, m_pixel_out);
            end else begin
                e = blurred_q.pop_front();
                if (m_pixel_out !== e.pixel)
                    note_mismatch("pixel_out", e.pixel, m_pixel_out);
                if (m_line_end_out !== e.line_end)
                    note_mismatch("line_end_out", e.line_end, m_line_end_out);
                if (m_run_last !== e.run_last)
                    note_mismatch("run_last", e.run_last, m_run_last);
            end
        end
    end

    // Drop the input valid, then wait until every result is in.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    // Write one weight register; the bench copy follows for valid indexes.
    task automatic write_weight(logic [glb_pkg::CFG_IDX_W-1:0] idx,
                                logic [glb_pkg::WGT_W-1:0] w);
        cfg_index <= idx;
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx < glb_pkg::NUM_TAPS) tap_w[idx[2:0]] = w;
    endtask

    // Offer one pixel beat with a random gap before it; hold until taken.
    // Valid stays high after the beat so that the next one can follow at once.
    task automatic send_pixel(logic [glb_pkg::PIX_W-1:0] pix, logic last,
                              output int n);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_pixel_in    <= pix;
        s_line_end_in <= last;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        n = push_pixel(pix, last);
    endtask

    // Directed table under reset weights (identity).
    pix_row_t dir_rows [] = '{
        '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},  // one-pixel line
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
        '{32'h8001_7F80, 1'b1, 1'b0, 32'h0},          // two-pixel line
        '{32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0},
        '{32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
        '{32'hFF00_FF00, 1'b0, 1'b0, 32'h0},
        '{32'h00FF_00FF, 1'b0, 1'b0, 32'h0},
        '{32'h0102_0408, 1'b0, 1'b0, 32'h0},
        '{32'h1020_4080, 1'b0, 1'b0, 32'h0},
        '{32'hFFFF_0000, 1'b0, 1'b0, 32'h0},
        '{32'h0000_FFFF, 1'b0, 1'b0, 32'h0},          // first steady result
        '{32'hDEAD_BEEF, 1'b1, 1'b0, 32'h0}           // flush of a long line
    };

    task automatic run_line(int len, bit noisy);
        int n;
        logic [glb_pkg::PIX_W-1:0] p;
        for (int i = 0; i < len; i++) begin
            p = $urandom();
            if (!noisy) p = {4{p[7:0]}} ^ ($urandom() & 32'h0F0F_0F0F);
            send_pixel(p, i == len - 1, n);
        end
    endtask

    task automatic random_weights(bit extreme);
        for (int i = 0; i < glb_pkg::NUM_TAPS; i++)
            write_weight(i[glb_pkg::CFG_IDX_W-1:0],
                         extreme ? (($urandom_range(1)) ? W_MAX : 16'h0000)
                                 : 16'($urandom_range(0, 32768)));
    endtask

    initial begin
        int n;
        int sent;
        for (int i = 0; i < glb_pkg::NUM_TAPS; i++) tap_w[i] = '0;
        tap_w[0] = W_ONE;
        for (int i = 0; i < WIN_DEPTH; i++) window[i] = '0;
        fill_cnt = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // identity kernel: the directed table; single-pixel lines read straight back
        for (int k = 0; k < dir_rows.size(); k++) begin
            send_pixel(dir_rows[k].pixel, dir_rows[k].line_end, n);
            if (dir_rows[k].has_check && n > 0)
                if (blurred_q[blurred_q.size() - n].pixel !== dir_rows[k].check_pixel)
                    note_mismatch("directed", dir_rows[k].check_pixel,
                                  blurred_q[blurred_q.size() - n].pixel);
        end
        wait_drained();

        // box kernel at full weight, all taps, a zero-sum kernel and weights above one
        for (int i = 0; i < glb_pkg::NUM_TAPS; i++)
            write_weight(i[glb_pkg::CFG_IDX_W-1:0], W_ONE);
        write_weight(IDX_BEYOND, 16'h1234);
        write_weight(IDX_TOP, W_MAX);
        run_line(20, 1'b1);
        run_line(3, 1'b1);
        wait_drained();
        for (int i = 0; i < glb_pkg::NUM_TAPS; i++)
            write_weight(i[glb_pkg::CFG_IDX_W-1:0], 16'h0000);
        run_line(9, 1'b1);   // every result zero
        wait_drained();
        for (int i = 0; i < glb_pkg::NUM_TAPS; i++)
            write_weight(i[glb_pkg::CFG_IDX_W-1:0], W_MAX);
        run_line(16, 1'b1);  // weights above one
        wait_drained();

        // random lines: first phase, sender rarely idle, receiver often idle
        sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 57 : 0;
            dst_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 6 : 0;
            random_weights(phase == 1);
            while (sent < 30 * (phase + 1)) begin
                // mostly short lines, a few past the fill saturation
                n = ($urandom_range(3) == 0) ? $urandom_range(16, 24)
                                              : $urandom_range(1, 9);
                run_line(n, $urandom_range(1));
                sent += n;
            end
            wait_drained();
        end

        // hold the receiver off while the sender keeps offering pixels
        fork
            begin
                dst_hold = 1'b1;
                repeat (400) @(posedge aclk);
                dst_hold = 1'b0;
            end
            run_line(22, 1'b1);
        join
        // pause the sender until every result is in, then send one more line
        s_valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge aclk);
        run_line(8, 1'b1);

        wait_drained();
        if (mismatches == 0 && blurred_q.size() == 0)
            $display("gaussian_line_blur_core_tb: PASS");
        else
            $display("gaussian_line_blur_core_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/glb_pkg.sv
sv/glb_front.sv
sv/glb_job_fifo.sv
sv/glb_back.sv
sv/gaussian_line_blur_core.sv
sv/glb_checker.sv
bench/gaussian_line_blur_core_tb.sv
